// ===== sv/ole_pkg.sv =====
// Shared constants, types and codes of the ordered list engine.
// Used by every module of the block and by its checker; depends on nothing.
package ole_pkg;

   localparam int CAPACITY   = 128;
   localparam int ELEM_WIDTH = 8;

   // Port field widths, fixed by the interface
   localparam int TYPE_W   = 2;
   localparam int POS_W    = 8;
   localparam int VAL_W    = 8;
   localparam int STATUS_W = 2;

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // Match/select reduction tree: groups of GROUP cells, then across groups
   localparam int GROUP   = 16;
   localparam int GRP_W   = $clog2(GROUP);
   localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;
   localparam int NG_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
   localparam int PADDED  = NGROUPS * GROUP;
   localparam int HPOS_W  = NG_W + GRP_W + 1;

   typedef logic [ELEM_WIDTH-1:0] elem_type;

   typedef enum logic [TYPE_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_GET    = 2'd2,
      REQ_LOCATE = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_MISS    = 2'd3
   } status_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic                 capture;
      logic                 shift_up;
      logic                 shift_down;
      logic [IDX_W-1:0]     pos_idx;
      elem_type             key;
      logic [CNT_W-1:0]     count;
   } cell_ctrl_type;

   // Registered summary of one group of cells
   typedef struct packed {
      logic                 any_hit;
      logic [GRP_W-1:0]     first_hit;
      elem_type             sel_data;
   } grp_result_type;

endpackage

// ===== sv/ole_cell.sv =====
// One storage cell of the ordered list: holds one element, shifts with its
// neighbors and flags a key match or a position select. Depends on ole_pkg.
module ole_cell (
   input  logic                      clock,
   input  ole_pkg::cell_ctrl_type    ctrl,
   input  logic [ole_pkg::IDX_W-1:0] cell_index,
   input  ole_pkg::elem_type         left_data,
   input  ole_pkg::elem_type         right_data,
   output ole_pkg::elem_type         data,
   output logic                      hit,
   output logic                      sel
);

   ole_pkg::elem_type data_ff, data_in;
   logic              hit_ff, hit_in;
   logic              sel_ff, sel_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (cell_index == ctrl.pos_idx) begin
            data_in = ctrl.key;
         end else if (cell_index > ctrl.pos_idx) begin
            data_in = left_data;
         end
      end else if (ctrl.shift_down && (cell_index >= ctrl.pos_idx)) begin
         data_in = right_data;
      end
   end

   always_comb begin
      hit_in = hit_ff;
      sel_in = sel_ff;
      if (ctrl.capture) begin
         // only occupied cells may match
         hit_in = (data_ff == ctrl.key) &&
                  (ole_pkg::CNT_W'(cell_index) < ctrl.count);
         sel_in = (cell_index == ctrl.pos_idx);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
      sel_ff  <= sel_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;
   assign sel  = sel_ff;

endmodule

// ===== sv/ole_group.sv =====
// Registered reduction over one group of cells: first matching cell and the
// data of the selected cell. Depends on ole_pkg.
module ole_group (
   input  logic                                              clock,
   input  logic                                              enable,
   input  logic [ole_pkg::GROUP-1:0]                         hits,
   input  logic [ole_pkg::GROUP-1:0]                         sels,
   input  logic [ole_pkg::GROUP-1:0][ole_pkg::ELEM_WIDTH-1:0] grp_data,
   output ole_pkg::grp_result_type                           result
);

   ole_pkg::grp_result_type result_ff, result_in, summary;

   always_comb begin
      summary = '0;
      // scan downward so the lowest matching cell wins
      for (int i = ole_pkg::GROUP - 1; i >= 0; i--) begin
         if (hits[i]) begin
            summary.any_hit   = 1'b1;
            summary.first_hit = ole_pkg::GRP_W'(i);
         end
      end
      for (int i = 0; i < ole_pkg::GROUP; i++) begin
         summary.sel_data = summary.sel_data | (grp_data[i] & {ole_pkg::ELEM_WIDTH{sels[i]}});
      end
   end

   always_comb begin
      result_in = enable ? summary : result_ff;
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== sv/ordered_list_engine.sv =====
// Top level of the ordered list engine: request decode, cell row, group
// reduction, result register. Depends on ole_pkg, ole_cell and ole_group.
//
// Usage:
//   The block keeps an ordered list of up to CAPACITY elements at 1-based
//   positions. A request carries req_type (insert, delete, get, locate),
//   req_position and req_element_value; it is taken at a clock edge where
//   req_valid is high and req_stall is low. Each request gives exactly one
//   response on the rsp_ channel: status, value_out, found_position and the
//   list length and empty flag after the request.
//   Timing: one request is in work at a time. After acceptance the cells
//   compare in parallel (ST_CMP), the group tree reduces 16 cells per
//   group (ST_GRP), and the final state ST_DONE resolves across groups,
//   shifts the cell row and loads the response register as it is left.
//   No new request is taken until the sequencer is back in ST_IDLE.
//   A stalled response holds in its register while the block already takes
//   the next request; that request waits in its final cycle until the
//   response register frees up.
//   Reset (synchronous, active high) empties the list and drops any
//   pending response. Element storage is not cleared: entries beyond the
//   length are never read.
module ordered_list_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ole_pkg::TYPE_W-1:0]   req_type,
   input  logic [ole_pkg::POS_W-1:0]    req_position,
   input  logic [ole_pkg::VAL_W-1:0]    req_element_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ole_pkg::STATUS_W-1:0] rsp_status,
   output logic [ole_pkg::VAL_W-1:0]    rsp_value_out,
   output logic [ole_pkg::POS_W-1:0]    rsp_found_position,
   output logic [ole_pkg::POS_W-1:0]    rsp_list_length,
   output logic                         rsp_list_empty
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMP  = 4'b0010,
      ST_GRP  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Request held for the duration of its work
   ole_pkg::req_kind_type         kind_ff, kind_in;
   ole_pkg::status_type           status_ff, status_in;
   logic [ole_pkg::IDX_W-1:0]     pos_idx_ff, pos_idx_in;
   ole_pkg::elem_type             key_ff, key_in;

   logic [ole_pkg::CNT_W-1:0]     count_ff, count_in;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   ole_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [ole_pkg::VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [ole_pkg::POS_W-1:0]     rsp_found_ff, rsp_found_in;
   logic [ole_pkg::POS_W-1:0]     rsp_length_ff, rsp_length_in;
   logic                          rsp_empty_ff, rsp_empty_in;

   logic                          accept;
   logic                          finish;
   ole_pkg::cell_ctrl_type        ctrl;

   logic [ole_pkg::PADDED-1:0]                         hit_vec;
   logic [ole_pkg::PADDED-1:0]                         sel_vec;
   logic [ole_pkg::PADDED-1:0][ole_pkg::ELEM_WIDTH-1:0] cell_data;
   ole_pkg::grp_result_type                            grp_res [ole_pkg::NGROUPS];

   ole_pkg::req_kind_type         new_kind;
   logic [ole_pkg::CMP_W-1:0]     pos_wide;
   logic [ole_pkg::CMP_W-1:0]     cnt_wide;

   logic                          any_hit;
   logic [ole_pkg::NG_W-1:0]      hit_grp;
   logic [ole_pkg::GRP_W-1:0]     hit_local;
   logic [ole_pkg::HPOS_W-1:0]    hit_pos;
   ole_pkg::elem_type             sel_data;
   logic                          req_ok;
   logic [ole_pkg::CNT_W-1:0]     next_count;

   assign accept = req_valid && !req_stall;
   // Leave the final cycle only when the response register can take the result
   assign finish = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);

   // ---------------- request decode ----------------
   always_comb begin
      new_kind = ole_pkg::req_kind_type'(req_type);
      pos_wide = ole_pkg::CMP_W'(req_position);
      cnt_wide = ole_pkg::CMP_W'(count_ff);
      status_in = status_ff;
      kind_in   = kind_ff;
      pos_idx_in = pos_idx_ff;
      key_in    = key_ff;
      if (accept) begin
         kind_in    = new_kind;
         // position is 1-based; only meaningful when the request checks out
         pos_idx_in = ole_pkg::IDX_W'(pos_wide - ole_pkg::CMP_W'(1));
         key_in     = ole_pkg::ELEM_WIDTH'(req_element_value);
         unique case (new_kind) inside
            ole_pkg::REQ_INSERT: begin
               if ((pos_wide == '0) || (pos_wide > cnt_wide + ole_pkg::CMP_W'(1))) begin
                  status_in = ole_pkg::STATUS_BAD_POS;
               end else if (cnt_wide == ole_pkg::CMP_W'(ole_pkg::CAPACITY)) begin
                  status_in = ole_pkg::STATUS_FULL;
               end else begin
                  status_in = ole_pkg::STATUS_OK;
               end
            end
            ole_pkg::REQ_DELETE, ole_pkg::REQ_GET: begin
               if (cnt_wide == '0) begin
                  status_in = ole_pkg::STATUS_MISS;
               end else if ((pos_wide == '0) || (pos_wide > cnt_wide)) begin
                  status_in = ole_pkg::STATUS_BAD_POS;
               end else begin
                  status_in = ole_pkg::STATUS_OK;
               end
            end
            ole_pkg::REQ_LOCATE: begin
               // decided once the cell row has been searched
               status_in = ole_pkg::STATUS_MISS;
            end
            default: begin
               status_in = ole_pkg::STATUS_MISS;
            end
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_GRP;
         end
         ST_GRP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- cell row ----------------
   assign req_ok = (status_ff == ole_pkg::STATUS_OK);

   always_comb begin
      ctrl.capture    = (state_ff == ST_CMP);
      ctrl.shift_up   = finish && req_ok && (kind_ff == ole_pkg::REQ_INSERT);
      ctrl.shift_down = finish && req_ok && (kind_ff == ole_pkg::REQ_DELETE);
      ctrl.pos_idx    = pos_idx_ff;
      ctrl.key        = key_ff;
      ctrl.count      = count_ff;
   end

   for (genvar i = 0; i < ole_pkg::PADDED; i++) begin : g_cell
      if (i < ole_pkg::CAPACITY) begin : g_real
         ole_pkg::elem_type left_d, right_d, data_d;
         logic              hit_d, sel_d;

         if (i == 0) begin : g_first
            assign left_d = key_ff;
         end else begin : g_inner_l
            assign left_d = cell_data[i-1];
         end
         if (i == ole_pkg::CAPACITY - 1) begin : g_last
            assign right_d = data_d;
         end else begin : g_inner_r
            assign right_d = cell_data[i+1];
         end

         ole_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .cell_index (ole_pkg::IDX_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (data_d),
            .hit        (hit_d),
            .sel        (sel_d)
         );

         assign cell_data[i] = data_d;
         assign hit_vec[i]   = hit_d;
         assign sel_vec[i]   = sel_d;
      end else begin : g_pad
         assign cell_data[i] = '0;
         assign hit_vec[i]   = 1'b0;
         assign sel_vec[i]   = 1'b0;
      end
   end

   // ---------------- group reduction ----------------
   for (genvar g = 0; g < ole_pkg::NGROUPS; g++) begin : g_grp
      ole_group u_group (
         .clock    (clock),
         .enable   (state_ff == ST_GRP),
         .hits     (hit_vec[g*ole_pkg::GROUP +: ole_pkg::GROUP]),
         .sels     (sel_vec[g*ole_pkg::GROUP +: ole_pkg::GROUP]),
         .grp_data (cell_data[g*ole_pkg::GROUP +: ole_pkg::GROUP]),
         .result   (grp_res[g])
      );
   end

   // Resolve across groups: lowest group with a match wins
   always_comb begin
      any_hit   = 1'b0;
      hit_grp   = '0;
      hit_local = '0;
      sel_data  = '0;
      for (int g = ole_pkg::NGROUPS - 1; g >= 0; g--) begin
         if (grp_res[g].any_hit) begin
            any_hit   = 1'b1;
            hit_grp   = ole_pkg::NG_W'(g);
            hit_local = grp_res[g].first_hit;
         end
      end
      for (int g = 0; g < ole_pkg::NGROUPS; g++) begin
         sel_data = sel_data | grp_res[g].sel_data;
      end
      hit_pos = {1'b0, hit_grp, hit_local} + ole_pkg::HPOS_W'(1);
   end

   // ---------------- length and response ----------------
   always_comb begin
      next_count = count_ff;
      if (req_ok && (kind_ff == ole_pkg::REQ_INSERT)) begin
         next_count = count_ff + ole_pkg::CNT_W'(1);
      end else if (req_ok && (kind_ff == ole_pkg::REQ_DELETE)) begin
         next_count = count_ff - ole_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      rsp_empty_in  = rsp_empty_ff;
      // drop a delivered response
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         count_in      = next_count;
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_found_in  = '0;
         rsp_status_in = status_ff;
         if (kind_ff == ole_pkg::REQ_LOCATE) begin
            if (any_hit) begin
               rsp_status_in = ole_pkg::STATUS_OK;
               rsp_found_in  = ole_pkg::POS_W'(hit_pos);
            end else begin
               rsp_status_in = ole_pkg::STATUS_MISS;
            end
         end else if (req_ok && ((kind_ff == ole_pkg::REQ_DELETE) ||
                                 (kind_ff == ole_pkg::REQ_GET))) begin
            rsp_value_in = ole_pkg::VAL_W'(sel_data);
         end
         rsp_length_in = ole_pkg::POS_W'(next_count);
         rsp_empty_in  = (next_count == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      pos_idx_ff    <= pos_idx_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_length_ff;
   assign rsp_list_empty     = rsp_empty_ff;

endmodule

// ===== sv/ole_checker.sv =====
// Port-level checker for the ordered list engine and its bind statement.
// Depends on ole_pkg and on the ports of ordered_list_engine.
module ole_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ole_pkg::STATUS_W-1:0] rsp_status,
   input logic [ole_pkg::VAL_W-1:0]    rsp_value_out,
   input logic [ole_pkg::POS_W-1:0]    rsp_found_position,
   input logic [ole_pkg::POS_W-1:0]    rsp_list_length,
   input logic                         rsp_list_empty
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_value_out) && $stable(rsp_found_position) &&
      $stable(rsp_list_length))
      else $error("stalled response changed");

   // One request in work at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // Empty flag agrees with the length
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_empty == (rsp_list_length == '0)))
      else $error("empty flag disagrees with length");

   // A failed request returns neither a value nor a position
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ole_pkg::STATUS_OK) |->
      (rsp_value_out == '0) && (rsp_found_position == '0))
      else $error("failed request carries data");

   // A found position never lies beyond the list
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_position != '0) |->
      (rsp_status == ole_pkg::STATUS_OK) && (rsp_found_position <= rsp_list_length))
      else $error("found position out of range");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);

// ===== sim/ordered_list_engine_test.sv =====
// Self-checking testbench for ordered_list_engine: directed edge cases, a fill to capacity,
// back pressure and a long random mix, checked against an in-bench list predictor.
// Depends on ole_pkg and the ordered_list_engine RTL.
module ordered_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_CYCLES     = 80;      // long receiver hold-off
   localparam int CYCLE_LIMIT     = 500000;
   localparam int RANDOM_REQUESTS = 300;
   localparam int SEGMENT_SIZE    = 50;
   localparam int MAX_REPORTS     = 40;

   // Which way a random segment pushes the list length
   typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_EVEN} drift_type;

   // One expected response
   typedef struct {
      ole_pkg::status_type       status;
      logic [ole_pkg::VAL_W-1:0] value;
      logic [ole_pkg::POS_W-1:0] found;
      logic [ole_pkg::POS_W-1:0] length;
      logic                      empty;
   } list_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [ole_pkg::TYPE_W-1:0]   req_type = '0;
   logic [ole_pkg::POS_W-1:0]    req_position = '0;
   logic [ole_pkg::VAL_W-1:0]    req_element_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [ole_pkg::STATUS_W-1:0] rsp_status;
   logic [ole_pkg::VAL_W-1:0]    rsp_value_out;
   logic [ole_pkg::POS_W-1:0]    rsp_found_position;
   logic [ole_pkg::POS_W-1:0]    rsp_list_length;
   logic                         rsp_list_empty;

   // Predictor state: a private copy of the list contents and its length
   ole_pkg::elem_type model_store [ole_pkg::CAPACITY];
   int                model_count = 0;
   list_result_type   pending_results [$];
   list_result_type   oldest_result;

   // Run bookkeeping
   int   error_count = 0;
   int   cycle_count = 0;
   int   kind_seen [4] = '{0, 0, 0, 0};
   int   status_seen [4] = '{0, 0, 0, 0};
   int   peak_length = 0;
   bit   steady = 1'b0;       // no sender gaps and no random receiver stalls while set
   int   hold_asked = 0;      // bumped by the stimulus to request a long hold-off
   int   hold_taken = 0;
   int   stall_left = 0;

   ordered_list_engine DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_value_out      (rsp_value_out),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .rsp_list_empty     (rsp_list_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Apply one request to the predictor list and return the response it must produce.
   // Insert checks the position before fullness; delete and get check emptiness first.
   function automatic list_result_type apply_request(ole_pkg::req_kind_type kind,
                                                     logic [ole_pkg::POS_W-1:0] pos,
                                                     logic [ole_pkg::VAL_W-1:0] val);
      list_result_type   res;
      int                p;
      int                k;
      ole_pkg::elem_type key;
      p          = int'(pos);
      key        = val;
      res.status = ole_pkg::STATUS_OK;
      res.value  = '0;
      res.found  = '0;
      case (kind)
         ole_pkg::REQ_INSERT: begin
            if (p == 0 || p > model_count + 1) begin
               res.status = ole_pkg::STATUS_BAD_POS;
            end else if (model_count >= ole_pkg::CAPACITY) begin
               res.status = ole_pkg::STATUS_FULL;
            end else begin
               // Open a slot at p by moving the tail up one place
               for (k = model_count; k >= p; k--)
                  model_store[k] = model_store[k-1];
               model_store[p-1] = key;
               model_count++;
            end
         end
         ole_pkg::REQ_DELETE: begin
            if (model_count == 0) begin
               res.status = ole_pkg::STATUS_MISS;
            end else if (p == 0 || p > model_count) begin
               res.status = ole_pkg::STATUS_BAD_POS;
            end else begin
               res.value = model_store[p-1];
               // Close the gap by moving the tail down one place
               for (k = p; k < model_count; k++)
                  model_store[k-1] = model_store[k];
               model_count--;
            end
         end
         ole_pkg::REQ_GET: begin
            if (model_count == 0)
               res.status = ole_pkg::STATUS_MISS;
            else if (p == 0 || p > model_count)
               res.status = ole_pkg::STATUS_BAD_POS;
            else
               res.value = model_store[p-1];
         end
         default: begin
            // Locate: first match from the head of the list wins
            res.status = ole_pkg::STATUS_MISS;
            for (k = 0; k < model_count; k++) begin
               if (model_store[k] == key) begin
                  res.found  = ole_pkg::POS_W'(k + 1);
                  res.status = ole_pkg::STATUS_OK;
                  break;
               end
            end
         end
      endcase
      res.length = ole_pkg::POS_W'(model_count);
      res.empty  = (model_count == 0);
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one request, hold it until accepted, then record its expected response.
   // Leave valid high when no gap follows so back-to-back requests never drop it.
   task automatic send_request(ole_pkg::req_kind_type kind,
                               logic [ole_pkg::POS_W-1:0] pos,
                               logic [ole_pkg::VAL_W-1:0] val);
      list_result_type res;
      int              gap;
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_position      <= pos;
      req_element_value <= val;
      do
         @(posedge clock);
      while (req_stall);
      res = apply_request(kind, pos, val);
      pending_results.push_back(res);
      kind_seen[kind]++;
      status_seen[res.status]++;
      if (model_count > peak_length)
         peak_length = model_count;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every response is back and the pipeline is quiet
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed requests with random content, some pure noise.
   // The drift biases insert against delete so the length wanders over its range.
   task automatic send_random_request(drift_type drift);
      ole_pkg::req_kind_type kind;
      ole_pkg::elem_type     v;
      int                    r;
      int                    ins_w;
      int                    del_w;
      int                    p;
      int                    max_pos;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         send_request(ole_pkg::req_kind_type'($urandom_range(0, 3)),
                      ole_pkg::POS_W'($urandom_range(0, 255)),
                      ole_pkg::VAL_W'($urandom_range(0, 255)));
         return;
      end
      ins_w = (drift == LEAN_GROW) ? 55 : (drift == LEAN_SHRINK) ? 15 : 35;
      del_w = (drift == LEAN_GROW) ? 15 : (drift == LEAN_SHRINK) ? 55 : 30;
      r = $urandom_range(0, 99);
      if (r < ins_w)
         kind = ole_pkg::REQ_INSERT;
      else if (r < ins_w + del_w)
         kind = ole_pkg::REQ_DELETE;
      else if ($urandom_range(0, 1))
         kind = ole_pkg::REQ_GET;
      else
         kind = ole_pkg::REQ_LOCATE;
      max_pos = (kind == ole_pkg::REQ_INSERT) ? model_count + 1 : model_count;
      if (max_pos == 0)
         max_pos = 1;
      // Favor the head and tail now and then, where shifting is most likely to break
      if ($urandom_range(0, 4) == 0)
         p = $urandom_range(0, 1) ? 1 : max_pos;
      else
         p = $urandom_range(1, max_pos);
      // Locate mostly values that are present; a narrow value range makes duplicates
      if (kind == ole_pkg::REQ_LOCATE && model_count > 0 && $urandom_range(0, 2) != 0)
         v = model_store[$urandom_range(0, model_count - 1)];
      else if ($urandom_range(0, 3) == 0)
         v = ole_pkg::ELEM_WIDTH'($urandom_range(0, 7));
      else
         v = ole_pkg::ELEM_WIDTH'($urandom_range(0, 255));
      send_request(kind, ole_pkg::POS_W'(p), v);
   endtask

   // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         stall_left = HOLD_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 30);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(string field, logic [31:0] expected,
                                       logic [31:0] actual);
      if (actual !== expected) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s wrong, expected %0d, actual %0d", $time, field, expected, actual);
      end
   endfunction

   // Compare every accepted response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response with none expected, expected nothing, actual status %0d",
                        $time, rsp_status);
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("status", 32'(oldest_result.status), 32'(rsp_status));
            check_field("value_out", 32'(oldest_result.value), 32'(rsp_value_out));
            check_field("found_position", 32'(oldest_result.found),
                        32'(rsp_found_position));
            check_field("list_length", 32'(oldest_result.length), 32'(rsp_list_length));
            check_field("list_empty", 32'(oldest_result.empty), 32'(rsp_list_empty));
         end
      end
   end

   // Every kind on an empty list, bad positions, insert at head, tail and middle,
   // get and delete at both ends, locate hit and miss
   task automatic test_empty_and_edges();
      send_request(ole_pkg::REQ_GET, 8'd1, 8'd0);
      send_request(ole_pkg::REQ_DELETE, 8'd1, 8'd0);
      send_request(ole_pkg::REQ_LOCATE, 8'd0, 8'd0);
      send_request(ole_pkg::REQ_INSERT, 8'd0, 8'd17);
      send_request(ole_pkg::REQ_INSERT, 8'd2, 8'd17);
      send_request(ole_pkg::REQ_INSERT, 8'd255, 8'd17);
      send_request(ole_pkg::REQ_INSERT, 8'd1, 8'h00);
      send_request(ole_pkg::REQ_INSERT, 8'd1, 8'hFF);
      send_request(ole_pkg::REQ_INSERT, 8'd3, 8'hA5);
      send_request(ole_pkg::REQ_INSERT, 8'd2, 8'h5A);
      send_request(ole_pkg::REQ_GET, 8'd0, 8'd0);
      send_request(ole_pkg::REQ_GET, 8'd5, 8'd0);
      send_request(ole_pkg::REQ_GET, 8'd1, 8'd0);
      send_request(ole_pkg::REQ_GET, 8'd4, 8'd0);
      send_request(ole_pkg::REQ_LOCATE, 8'd0, 8'hA5);
      send_request(ole_pkg::REQ_LOCATE, 8'd0, 8'h77);
      send_request(ole_pkg::REQ_DELETE, 8'd0, 8'd0);
      send_request(ole_pkg::REQ_DELETE, 8'd5, 8'd0);
      send_request(ole_pkg::REQ_DELETE, 8'd2, 8'd0);
      send_request(ole_pkg::REQ_DELETE, 8'd1, 8'd0);
      send_request(ole_pkg::REQ_GET, 8'd255, 8'd0);
      send_request(ole_pkg::REQ_DELETE, 8'd2, 8'd0);
      send_request(ole_pkg::REQ_DELETE, 8'd1, 8'd0);
      send_request(ole_pkg::REQ_LOCATE, 8'd0, 8'hFF);
      wait_for_results();
   endtask

   // Fill to capacity with no idling, poke the full list, then empty it again
   task automatic test_fill_to_capacity();
      ole_pkg::elem_type v;
      steady = 1'b1;
      while (model_count < ole_pkg::CAPACITY) begin
         v = ($urandom_range(0, 3) == 0) ? 8'h3C : ole_pkg::ELEM_WIDTH'($urandom_range(0, 255));
         send_request(ole_pkg::REQ_INSERT,
                      ole_pkg::POS_W'($urandom_range(1, model_count + 1)), v);
      end
      steady = 1'b0;
      send_request(ole_pkg::REQ_INSERT, ole_pkg::POS_W'(ole_pkg::CAPACITY + 1), 8'd1);
      send_request(ole_pkg::REQ_INSERT, 8'd1, 8'd1);
      send_request(ole_pkg::REQ_INSERT, 8'd0, 8'd1);
      send_request(ole_pkg::REQ_INSERT, 8'd200, 8'd1);
      send_request(ole_pkg::REQ_GET, ole_pkg::POS_W'(ole_pkg::CAPACITY), 8'd0);
      send_request(ole_pkg::REQ_GET, ole_pkg::POS_W'(ole_pkg::CAPACITY + 1), 8'd0);
      send_request(ole_pkg::REQ_LOCATE, 8'd0, 8'h3C);
      send_request(ole_pkg::REQ_LOCATE, 8'd0, model_store[ole_pkg::CAPACITY-1]);
      send_request(ole_pkg::REQ_DELETE, ole_pkg::POS_W'(ole_pkg::CAPACITY), 8'd0);
      send_request(ole_pkg::REQ_INSERT, ole_pkg::POS_W'(ole_pkg::CAPACITY), 8'hC3);
      send_request(ole_pkg::REQ_DELETE, 8'd1, 8'd0);
      while (model_count > 0) begin
         if ($urandom_range(0, 5) == 0)
            send_request(ole_pkg::REQ_LOCATE, 8'd0, ole_pkg::VAL_W'($urandom_range(0, 255)));
         send_request(ole_pkg::REQ_DELETE, ole_pkg::POS_W'($urandom_range(1, model_count)),
                      8'd0);
      end
      send_request(ole_pkg::REQ_DELETE, 8'd1, 8'd0);
      send_request(ole_pkg::REQ_GET, 8'd1, 8'd0);
      wait_for_results();
   endtask

   // Hold the receiver off while requests keep coming, so the block backs up
   // and stalls its input; pause the sender until everything is back between rounds
   task automatic test_back_pressure();
      steady     = 1'b1;
      hold_asked = hold_asked + 1;
      repeat (16) send_random_request(LEAN_GROW);
      steady = 1'b0;
      wait_for_results();
      hold_asked = hold_asked + 1;
      repeat (16) send_random_request(LEAN_EVEN);
      wait_for_results();
   endtask

   // Long random mix in segments; each segment picks a drift and, now and then,
   // runs with no idling at all
   task automatic test_random_mix();
      drift_type drift;
      int        seg;
      for (seg = 0; seg < RANDOM_REQUESTS / SEGMENT_SIZE; seg++) begin
         if (model_count > 100)
            drift = LEAN_SHRINK;
         else if (model_count < 20)
            drift = LEAN_GROW;
         else
            drift = drift_type'($urandom_range(0, 2));
         steady = ($urandom_range(0, 3) == 0);
         repeat (SEGMENT_SIZE) send_random_request(drift);
      end
      steady = 1'b0;
      wait_for_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_edges();
      test_fill_to_capacity();
      test_back_pressure();
      test_random_mix();
      wait_for_results();
      $display("Covered %0d inserts, %0d deletes, %0d gets, %0d locates; peak length %0d",
               kind_seen[ole_pkg::REQ_INSERT], kind_seen[ole_pkg::REQ_DELETE],
               kind_seen[ole_pkg::REQ_GET], kind_seen[ole_pkg::REQ_LOCATE], peak_length);
      $display("Outcomes: %0d ok, %0d bad position, %0d full, %0d empty or not found",
               status_seen[ole_pkg::STATUS_OK], status_seen[ole_pkg::STATUS_BAD_POS],
               status_seen[ole_pkg::STATUS_FULL], status_seen[ole_pkg::STATUS_MISS]);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ole_pkg.sv
sv/ole_cell.sv
sv/ole_group.sv
sv/ordered_list_engine.sv
sv/ole_checker.sv
sim/ordered_list_engine_test.sv
